// ----- src/sha256_pkg.sv -----
package sha256_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  // Buffer byte source selects.
  localparam logic [1:0] BSEL_DATA = 2'd0;
  localparam logic [1:0] BSEL_MARK = 2'd1;
  localparam logic [1:0] BSEL_ZERO = 2'd2;
  localparam logic [1:0] BSEL_LEN  = 2'd3;

  typedef struct packed {
    logic       buf_we;
    logic [1:0] buf_sel;
    logic [5:0] buf_addr;
    logic       load_word;
    logic [3:0] load_idx;
    logic       round_en;
    logic [5:0] round_idx;
    logic       hash_add;
    logic       hash_init;
    logic       bits_add_block;
    logic       bits_latch_total;
    logic       out_shift;
  } dp_cmd_t;

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[idx];
  endfunction

  function automatic logic [255:0] init_hash();
    return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  endfunction

endpackage

// ----- src/sha256_datapath.sv -----
module sha256_datapath
  import sha256_pkg::*;
(
  input  logic        clk,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  data_byte,
  input  logic [5:0]  fill,
  output logic [31:0] head_word
);

  logic [7:0]   block_mem [64];
  logic [7:0]   rd_byte;
  logic [7:0]   wr_byte;
  logic [31:0]  load_acc;
  logic [31:0]  w [16];
  logic [31:0]  hash [8];
  logic [31:0]  v [8];
  logic [63:0]  message_bits;
  logic [63:0]  total;
  logic [31:0]  w_new;
  logic [31:0]  w_cur;
  logic [31:0]  s0;
  logic [31:0]  s1;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [2:0]   len_sel;
  logic [255:0] iv_words;

  assign iv_words = init_hash();

  // Length field byte: bits of the wrapped total, big-endian.
  assign len_sel = cmd.buf_addr[2:0];
  always_comb begin
    case (cmd.buf_sel)
      BSEL_DATA: wr_byte = data_byte;
      BSEL_MARK: wr_byte = PAD_MARK;
      BSEL_ZERO: wr_byte = 8'd0;
      BSEL_LEN:  wr_byte = total[8'(7 - len_sel) * 8 +: 8];
      default:   wr_byte = 8'd0;
    endcase
  end

  // Block buffer memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.buf_we) begin
      block_mem[cmd.buf_addr] <= wr_byte;
    end
    rd_byte <= block_mem[cmd.buf_addr];
  end

  // Schedule word for the current round.
  always_comb begin
    s1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    s0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    w_new = s1 + w[9] + s0 + w[0];
    w_cur = (cmd.round_idx < 6'd16) ? w[0] : w_new;
  end

  // One compression round.
  always_comb begin
    t1 = v[7] + ({v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^
         {v[4][24:0], v[4][31:25]}) + ((v[4] & v[5]) ^ (~v[4] & v[6])) +
         round_const(cmd.round_idx) + w_cur;
    t2 = ({v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^
         {v[0][21:0], v[0][31:22]}) +
         ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // Byte loads shift bytes into an accumulator; a full word enters the window.
  always_ff @(posedge clk) begin
    load_acc <= {load_acc[23:0], rd_byte};
    if (cmd.load_word) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= {load_acc[23:0], rd_byte};
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= w_cur;
    end
  end

  // Working variables, hash words and bit count.
  always_ff @(posedge clk) begin
    if (cmd.hash_init) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= iv_words[255 - 32 * i -: 32];
      end
      message_bits <= 64'd0;
    end else begin
      if (cmd.hash_add) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + v[i];
        end
      end else if (cmd.out_shift) begin
        for (int i = 0; i < 7; i++) begin
          hash[i] <= hash[i + 1];
        end
        hash[7] <= hash[0];
      end
      if (cmd.bits_add_block) begin
        message_bits <= message_bits + 64'd512;
      end
    end
    if (cmd.bits_latch_total) begin
      total <= message_bits + {55'd0, fill, 3'd0};
    end
    if (cmd.round_en) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end else if (cmd.load_word && cmd.load_idx == 4'd0) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= hash[i];
      end
    end
  end

  assign head_word = hash[0];

endmodule

// ----- src/sha256_ctrl.sv -----
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_func,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_index,
  output logic [5:0] fill,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_WLAST = 3'd6;

  logic [2:0] state;
  logic [5:0] cnt;
  logic       finishing;
  logic       final_block;
  logic [2:0] out_cnt;
  logic       accept;
  logic       out_xfer;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == S_OUT);
  assign out_xfer  = out_valid && out_ready;
  assign out_index = out_cnt;

  // Command decode for the datapath.
  always_comb begin
    cmd = '0;
    cmd.buf_addr = fill;
    cmd.buf_sel  = BSEL_DATA;
    case (state)
      S_IDLE: begin
        cmd.buf_we = accept;
        cmd.buf_sel = (in_func == FUNC_FINISH) ? BSEL_MARK : BSEL_DATA;
        cmd.bits_latch_total = accept && (in_func == FUNC_FINISH);
      end
      S_PAD: begin
        cmd.buf_we = 1'b1;
        cmd.buf_addr = cnt;
        if (final_block && cnt >= LEN_POS) begin
          cmd.buf_sel = BSEL_LEN;
        end else begin
          cmd.buf_sel = BSEL_ZERO;
        end
      end
      S_LOAD: begin
        cmd.buf_addr = cnt;
        cmd.load_word = (cnt[1:0] == 2'd0) && (cnt != 6'd0);
        cmd.load_idx = cnt[5:2];
      end
      S_WLAST: begin
        // The last schedule word enters the window and the working
        // variables take the hash words.
        cmd.load_word = 1'b1;
        cmd.load_idx = 4'd0;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        cmd.round_idx = cnt;
      end
      S_ADD: begin
        cmd.hash_add = 1'b1;
        cmd.bits_add_block = !finishing;
      end
      S_OUT: begin
        cmd.out_shift = out_xfer;
        cmd.hash_init = out_xfer && (out_cnt == 3'd7);
      end
      default: begin
        cmd = '0;
      end
    endcase
    // Reset loads the initial hash and clears the bit count.
    if (rst) begin
      cmd = '0;
      cmd.hash_init = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      fill <= '0;
      finishing <= 1'b0;
      final_block <= 1'b0;
      out_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_func == FUNC_FINISH) begin
              finishing <= 1'b1;
              final_block <= (fill < 6'd56);
              cnt <= fill + 6'd1;
              state <= (fill == 6'd63) ? S_LOAD : S_PAD;
              if (fill == 6'd63) begin
                cnt <= '0;
              end
            end else begin
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                cnt <= '0;
                state <= S_LOAD;
              end
            end
          end
        end
        S_PAD: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            cnt <= '0;
            state <= S_WLAST;
          end
        end
        S_WLAST: begin
          cnt <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            cnt <= '0;
            state <= S_ADD;
          end
        end
        S_ADD: begin
          fill <= '0;
          if (!finishing) begin
            state <= S_IDLE;
          end else if (!final_block) begin
            final_block <= 1'b1;
            cnt <= '0;
            state <= S_PAD;
          end else begin
            out_cnt <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            out_cnt <= out_cnt + 3'd1;
            if (out_cnt == 3'd7) begin
              finishing <= 1'b0;
              final_block <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/sha256_stream_hasher.sv -----
// Streaming SHA-256 hasher.
// The in channel carries one item per transfer: an absorb item with one
// message byte, or a finish item that pads the message and produces the
// digest. The out channel carries the eight digest words H0..H7 in order,
// each with its index, and last_word set on the eighth.
// An absorb item that does not complete a block leaves in_ready high.
// The 64th byte of a block starts the compression: buffer reads that
// assemble the schedule words, a step for the last word, then 64 rounds
// of one shared round unit, then the hash update, all before the next
// item is taken. Input thus waits while a block is compressed, a limit
// set by the single-port block buffer and the one-round-per-cycle
// compression loop. A finish item writes the padding, compresses one or
// two blocks, and then offers the digest words one per cycle while the
// receiver is ready. While the receiver stalls, the current word holds
// and no input is taken.
// Reset loads the standard initial hash values and clears the byte and
// bit counts; after the eighth word the block returns to that state.
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t     cmd;
  logic [5:0]  fill;
  logic [2:0]  out_index;
  logic [31:0] head_word;

  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_index (out_index),
    .fill      (fill),
    .cmd       (cmd)
  );

  sha256_datapath u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .data_byte (in_data.data_byte),
    .fill      (fill),
    .head_word (head_word)
  );

  // Result fields.
  assign out_data.digest_word = head_word;
  assign out_data.word_index  = out_index;
  assign out_data.last_word   = (out_index == 3'd7);

endmodule
